/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks shared by the date unit rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property on clk_i, off during reset
`define GDAU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define GDAU_ASSERT_IMP(name, pre, con, msg) \
  `GDAU_ASSERT(name, (pre) |-> (con), msg)

`endif

/* rtl/gdau_pkg.sv */
// ---------------------------------------------------------------------------
// gdau_pkg
// types, constants and calendar helpers of the gregorian date unit
// ---------------------------------------------------------------------------
package gdau_pkg;

  typedef enum logic [3:0] {
    CMD_QUERY       = 4'd0,
    CMD_FROM_DAYS   = 4'd1,
    CMD_ADD_DAYS    = 4'd2,
    CMD_ADD_MONTHS  = 4'd3,
    CMD_ADD_YEARS   = 4'd4,
    CMD_DIFF        = 4'd5,
    CMD_MONTH_START = 4'd6,
    CMD_MONTH_END   = 4'd7,
    CMD_YEAR_START  = 4'd8,
    CMD_YEAR_END    = 4'd9
  } cmd_e;

  localparam logic [13:0] YEAR_MAX      = 14'd9999;
  localparam logic [21:0] X_MAX         = 22'd3652424;
  localparam logic [21:0] EPOCH_X       = 22'd719528;
  localparam logic [16:0] MONTHS_MAX    = 17'd120000;
  localparam logic [23:0] YEAR_RECIP    = 24'd11759217;
  localparam logic [22:0] SEVEN_RECIP   = 23'd4793491;
  localparam logic [12:0] HUNDRED_RECIP = 13'd5243;
  localparam logic [15:0] THIRD_RECIP   = 16'd43691;

  typedef struct packed {
    logic               vld;
    logic               ok;
    logic [21:0]        x;
    logic signed [22:0] diff;
    logic signed [1:0]  ord;
  } front_t;

  typedef struct packed {
    logic               ok;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [22:0] day_number;
    logic [2:0]         weekday;
    logic [8:0]         day_of_year;
    logic               leap;
    logic [4:0]         month_length;
    logic signed [22:0] day_diff;
    logic signed [1:0]  order;
  } res_t;

  function automatic logic [9:0] div100(input logic [15:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'(HUNDRED_RECIP);
    return p[28:19];
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    logic [9:0]  q;
    logic [15:0] c;
    logic        hund;
    q    = div100({2'b00, y});
    c    = 16'(q) * 16'd100;
    hund = (c == {2'b00, y});
    return (y[1:0] == 2'b00) && (!hund || (q[1:0] == 2'b00));
  endfunction

  // days from 0000-01-01 to the first day of year y
  function automatic logic [21:0] days_before(input logic [14:0] y);
    logic [21:0] base;
    logic [15:0] y4;
    logic [16:0] y400;
    logic [9:0]  c100;
    logic [9:0]  c400;
    base = 22'(y) * 22'd365;
    y4   = (16'(y) + 16'd3) >> 2;
    c100 = div100(16'(y) + 16'd99);
    y400 = (17'(y) + 17'd399) >> 2;
    c400 = div100(y400[15:0]);
    return base + 22'(y4) - 22'(c100) + 22'(c400);
  endfunction

  function automatic logic [4:0] month_len(input logic lp, input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = lp ? 5'd29 : 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] day_of_year(input logic lp, input logic [3:0] m,
                                             input logic [4:0] d);
    return cum_days(m) + 9'((m > 4'd2) && lp) + 9'(d);
  endfunction

endpackage

/* rtl/gdau_front.sv */
// ---------------------------------------------------------------------------
// gdau_front
// four stages: decode and check, date to day count, command resolve, and
// the day count of the result date
// ---------------------------------------------------------------------------
module gdau_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [3:0]            cmd_i,
  input  logic [13:0]           year_i,
  input  logic [3:0]            month_i,
  input  logic [4:0]            day_i,
  input  logic signed [22:0]    offset_i,
  input  logic [13:0]           year_b_i,
  input  logic [3:0]            month_b_i,
  input  logic [4:0]            day_b_i,
  output gdau_pkg::front_t      fr_o
);

  // stage 1
  logic                  lpa, lpb, va, vb;
  logic [4:0]            mla, mlb;
  logic                  vld1_q;
  gdau_pkg::cmd_e        cmd1_q;
  logic [13:0]           y1_q, yb1_q;
  logic [3:0]            m1_q;
  logic [4:0]            d1_q;
  logic signed [22:0]    off1_q;
  logic                  va1_q, vb1_q, lpa1_q;
  logic signed [24:0]    tot1_d, tot1_q, ry4_1_d, ry4_1_q;
  logic [8:0]            doya1_q, doyb1_q;

  always_comb begin
    lpa     = gdau_pkg::is_leap(year_i);
    lpb     = gdau_pkg::is_leap(year_b_i);
    mla     = gdau_pkg::month_len(lpa, month_i);
    mlb     = gdau_pkg::month_len(lpb, month_b_i);
    va      = (year_i <= gdau_pkg::YEAR_MAX) && (day_i != 5'd0) && (day_i <= mla);
    vb      = (year_b_i <= gdau_pkg::YEAR_MAX) && (day_b_i != 5'd0) && (day_b_i <= mlb);
    tot1_d  = 25'(year_i) * 25'd12 + 25'(month_i) - 25'd1 + 25'(offset_i);
    ry4_1_d = 25'(year_i) + 25'(offset_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q  <= gdau_pkg::cmd_e'(cmd_i);
      y1_q    <= year_i;
      m1_q    <= month_i;
      d1_q    <= day_i;
      yb1_q   <= year_b_i;
      off1_q  <= offset_i;
      va1_q   <= va;
      vb1_q   <= vb;
      lpa1_q  <= lpa;
      tot1_q  <= tot1_d;
      ry4_1_q <= ry4_1_d;
      doya1_q <= gdau_pkg::day_of_year(lpa, month_i, day_i);
      doyb1_q <= gdau_pkg::day_of_year(lpb, month_b_i, day_b_i);
    end
  end

  // stage 2
  logic [21:0]        xa2_d, xb2_d;
  logic               tot_ok, y4ok, lp4;
  logic [30:0]        p3;
  logic               ok2_d;
  logic [13:0]        ry2_d;
  logic [3:0]         rm2_d;
  logic [4:0]         rd2_d, d4;
  logic               vld2_q, ok2_q;
  gdau_pkg::cmd_e     cmd2_q;
  logic [13:0]        ry2_q, q2_q;
  logic [3:0]         rm2_q;
  logic [4:0]         rd2_q;
  logic [21:0]        xa2_q, xb2_q;
  logic signed [22:0] off2_q;
  logic [16:0]        tlo2_q;

  always_comb begin
    xa2_d  = gdau_pkg::days_before({1'b0, y1_q}) + 22'(doya1_q) - 22'd1;
    xb2_d  = gdau_pkg::days_before({1'b0, yb1_q}) + 22'(doyb1_q) - 22'd1;
    tot_ok = (tot1_q >= 25'sd0) && (tot1_q < $signed(25'(gdau_pkg::MONTHS_MAX)));
    p3     = 31'(tot1_q[16:2]) * 31'(gdau_pkg::THIRD_RECIP);
    y4ok   = (ry4_1_q >= 25'sd0) && (ry4_1_q <= $signed(25'(gdau_pkg::YEAR_MAX)));
    lp4    = gdau_pkg::is_leap(ry4_1_q[13:0]);
    d4     = ((m1_q == 4'd2) && (d1_q == 5'd29) && !lp4) ? 5'd28 : d1_q;
    ry2_d  = y1_q;
    rm2_d  = m1_q;
    rd2_d  = d1_q;
    unique case (cmd1_q)
      gdau_pkg::CMD_QUERY:      ok2_d = va1_q;
      gdau_pkg::CMD_FROM_DAYS:  ok2_d = 1'b1;
      gdau_pkg::CMD_ADD_DAYS:   ok2_d = va1_q;
      gdau_pkg::CMD_ADD_MONTHS: ok2_d = va1_q && tot_ok;
      gdau_pkg::CMD_ADD_YEARS: begin
        ok2_d = va1_q && y4ok;
        ry2_d = ry4_1_q[13:0];
        rd2_d = d4;
      end
      gdau_pkg::CMD_DIFF:        ok2_d = va1_q && vb1_q;
      gdau_pkg::CMD_MONTH_START: begin
        ok2_d = va1_q;
        rd2_d = 5'd1;
      end
      gdau_pkg::CMD_MONTH_END: begin
        ok2_d = va1_q;
        rd2_d = gdau_pkg::month_len(lpa1_q, m1_q);
      end
      gdau_pkg::CMD_YEAR_START: begin
        ok2_d = va1_q;
        rm2_d = 4'd1;
        rd2_d = 5'd1;
      end
      gdau_pkg::CMD_YEAR_END: begin
        ok2_d = va1_q;
        rm2_d = 4'd12;
        rd2_d = 5'd31;
      end
      default: ok2_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd2_q <= cmd1_q;
      ok2_q  <= ok2_d;
      ry2_q  <= ry2_d;
      rm2_q  <= rm2_d;
      rd2_q  <= rd2_d;
      xa2_q  <= xa2_d;
      xb2_q  <= xb2_d;
      off2_q <= off1_q;
      tlo2_q <= tot1_q[16:0];
      q2_q   <= p3[30:17];
    end
  end

  // stage 3
  logic [16:0]        r12;
  logic [3:0]         rm3m;
  logic               lp3;
  logic [4:0]         ml3;
  logic signed [24:0] sx;
  logic               in_rng;
  logic signed [22:0] dv;
  logic               ok3_d, usex3_d;
  logic [13:0]        ry3_d;
  logic [3:0]         rm3_d;
  logic [4:0]         rd3_d;
  logic signed [22:0] diff3_d;
  logic signed [1:0]  ord3_d;
  logic               vld3_q, ok3_q, usex3_q;
  logic [21:0]        x3_q;
  logic [13:0]        ry3_q;
  logic [3:0]         rm3_q;
  logic [4:0]         rd3_q;
  logic signed [22:0] diff3_q;
  logic signed [1:0]  ord3_q;

  always_comb begin
    r12    = tlo2_q - 17'(q2_q) * 17'd12;
    rm3m   = r12[3:0] + 4'd1;
    lp3    = gdau_pkg::is_leap(q2_q);
    ml3    = gdau_pkg::month_len(lp3, rm3m);
    if (cmd2_q == gdau_pkg::CMD_FROM_DAYS) begin
      sx = 25'(off2_q) + 25'(gdau_pkg::EPOCH_X);
    end else begin
      sx = 25'(xa2_q) + 25'(off2_q);
    end
    in_rng  = (sx >= 25'sd0) && (sx <= $signed(25'(gdau_pkg::X_MAX)));
    dv      = 23'(xa2_q) - 23'(xb2_q);
    ok3_d   = ok2_q;
    usex3_d = 1'b0;
    ry3_d   = ry2_q;
    rm3_d   = rm2_q;
    rd3_d   = rd2_q;
    diff3_d = '0;
    ord3_d  = '0;
    unique case (cmd2_q)
      gdau_pkg::CMD_FROM_DAYS, gdau_pkg::CMD_ADD_DAYS: begin
        ok3_d   = ok2_q && in_rng;
        usex3_d = 1'b1;
      end
      gdau_pkg::CMD_ADD_MONTHS: begin
        ry3_d = q2_q;
        rm3_d = rm3m;
        rd3_d = (rd2_q > ml3) ? ml3 : rd2_q;
      end
      gdau_pkg::CMD_DIFF: begin
        diff3_d = dv;
        ord3_d  = (dv < 23'sd0) ? -2'sd1 : ((dv > 23'sd0) ? 2'sd1 : 2'sd0);
      end
      default: ok3_d = ok2_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok3_q   <= ok3_d;
      usex3_q <= usex3_d;
      x3_q    <= sx[21:0];
      ry3_q   <= ry3_d;
      rm3_q   <= rm3_d;
      rd3_q   <= rd3_d;
      diff3_q <= diff3_d;
      ord3_q  <= ord3_d;
    end
  end

  // stage 4
  logic             lp4b;
  logic [21:0]      x4_d;
  logic             vld4_q;
  gdau_pkg::front_t fr_q;

  always_comb begin
    lp4b = gdau_pkg::is_leap(ry3_q);
    if (usex3_q) begin
      x4_d = x3_q;
    end else begin
      x4_d = gdau_pkg::days_before({1'b0, ry3_q})
           + 22'(gdau_pkg::day_of_year(lp4b, rm3_q, rd3_q)) - 22'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fr_q.vld  <= 1'b0;
      fr_q.ok   <= ok3_q;
      fr_q.x    <= x4_d;
      fr_q.diff <= diff3_q;
      fr_q.ord  <= ord3_q;
    end
  end

  always_comb begin
    fr_o     = fr_q;
    fr_o.vld = vld4_q;
  end

endmodule

/* rtl/gdau_civil.sv */
// ---------------------------------------------------------------------------
// gdau_civil
// three stages from a day count to year, month, day, weekday and day of year
// ---------------------------------------------------------------------------
module gdau_civil (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  gdau_pkg::front_t fr_i,
  output logic             vld_o,
  output gdau_pkg::res_t   res_o
);

  // stage 5: year estimate and weekday quotient
  logic [45:0]        pe;
  logic [21:0]        v7;
  logic [44:0]        pw;
  logic               vld5_q, ok5_q;
  logic [21:0]        x5_q;
  logic [13:0]        e5_q;
  logic [19:0]        q7_5_q;
  logic signed [22:0] diff5_q;
  logic signed [1:0]  ord5_q;

  always_comb begin
    pe = 46'(fr_i.x) * 46'(gdau_pkg::YEAR_RECIP);
    v7 = fr_i.x + 22'd6;
    pw = 45'(v7) * 45'(gdau_pkg::SEVEN_RECIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld5_q <= 1'b0;
    end else if (en_i) begin
      vld5_q <= fr_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok5_q   <= fr_i.ok;
      x5_q    <= fr_i.x;
      e5_q    <= pe[45:32];
      q7_5_q  <= pw[44:25];
      diff5_q <= fr_i.diff;
      ord5_q  <= fr_i.ord;
    end
  end

  // stage 6: year correction and weekday
  logic [14:0]        e15;
  logic [21:0]        s_lo, s_mid, s_hi, st;
  logic [13:0]        y6_d;
  logic [21:0]        v6;
  logic               vld6_q, ok6_q;
  logic [21:0]        x6_q;
  logic [13:0]        y6_q;
  logic [8:0]         doy0_6_q;
  logic [2:0]         wd6_q;
  logic signed [22:0] diff6_q;
  logic signed [1:0]  ord6_q;

  always_comb begin
    e15   = {1'b0, e5_q};
    s_lo  = gdau_pkg::days_before(e15 - 15'd1);
    s_mid = gdau_pkg::days_before(e15);
    s_hi  = gdau_pkg::days_before(e15 + 15'd1);
    v6    = x5_q + 22'd6;
    priority if (x5_q >= s_hi) begin
      y6_d = e5_q + 14'd1;
      st   = s_hi;
    end else if (x5_q >= s_mid) begin
      y6_d = e5_q;
      st   = s_mid;
    end else begin
      y6_d = e5_q - 14'd1;
      st   = s_lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld6_q <= 1'b0;
    end else if (en_i) begin
      vld6_q <= vld5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok6_q    <= ok5_q;
      x6_q     <= x5_q;
      y6_q     <= y6_d;
      doy0_6_q <= 9'(x5_q - st);
      wd6_q    <= 3'(v6 - 22'(q7_5_q) * 22'd7);
      diff6_q  <= diff5_q;
      ord6_q   <= ord5_q;
    end
  end

  // stage 7: month search and result register
  logic           lp;
  logic [3:0]     mon;
  logic [8:0]     cm;
  logic [8:0]     dd;
  gdau_pkg::res_t res_d;
  logic           vld7_q;
  gdau_pkg::res_t res_q;

  always_comb begin
    lp  = gdau_pkg::is_leap(y6_q);
    mon = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (doy0_6_q >= gdau_pkg::cum_days(4'(i)) + 9'((i > 2) && lp)) begin
        mon = 4'(i);
      end
    end
    cm  = gdau_pkg::cum_days(mon) + 9'((mon > 4'd2) && lp);
    dd  = doy0_6_q - cm + 9'd1;
    res_d = '0;
    if (ok6_q) begin
      res_d.ok           = 1'b1;
      res_d.year         = y6_q;
      res_d.month        = mon;
      res_d.day          = dd[4:0];
      res_d.day_number   = 23'(x6_q) - 23'(gdau_pkg::EPOCH_X);
      res_d.weekday      = wd6_q;
      res_d.day_of_year  = doy0_6_q + 9'd1;
      res_d.leap         = lp;
      res_d.month_length = gdau_pkg::month_len(lp, mon);
      res_d.day_diff     = diff6_q;
      res_d.order        = ord6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld7_q <= 1'b0;
    end else if (en_i) begin
      vld7_q <= vld6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign vld_o = vld7_q;
  assign res_o = res_q;

endmodule

/* rtl/gregorian_date_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// gregorian_date_arithmetic_unit
// stream unit for proleptic gregorian date queries, shifts and differences
// ---------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and returns one
// result per request, in order. Every request flows through a seven-stage
// pipeline (four stages that resolve the command to a day count, three that
// turn the day count back into a calendar date); all stages advance together
// whenever the output register is empty or its result is being taken, so a
// stalled output holds the whole pipe and nothing is lost or repeated.
`include "assert_macros.svh"

module gregorian_date_arithmetic_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year, month, day, offset, year_b, month_b, day_b
  input  logic [71:0] s_axis_tdata,
  // cmd
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_year, out_month, out_day, day_number, weekday, day_of_year, leap,
  // month_length, day_diff, order
  output logic [95:0] m_axis_tdata,
  // ok
  output logic [0:0]  m_axis_tuser
);

  logic             en;
  gdau_pkg::front_t fr;
  gdau_pkg::res_t   res;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  gdau_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (s_axis_tvalid),
    .cmd_i     (s_axis_tuser),
    .year_i    (s_axis_tdata[13:0]),
    .month_i   (s_axis_tdata[17:14]),
    .day_i     (s_axis_tdata[22:18]),
    .offset_i  ($signed(s_axis_tdata[45:23])),
    .year_b_i  (s_axis_tdata[59:46]),
    .month_b_i (s_axis_tdata[63:60]),
    .day_b_i   (s_axis_tdata[68:64]),
    .fr_o      (fr)
  );

  gdau_civil u_civil (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .fr_i   (fr),
    .vld_o  (m_axis_tvalid),
    .res_o  (res)
  );

  assign m_axis_tdata = {7'b0, res.order, res.day_diff, res.month_length, res.leap,
                         res.day_of_year, res.weekday, res.day_number, res.day,
                         res.month, res.year};
  assign m_axis_tuser = res.ok;

  `GDAU_ASSERT_IMP(a_fail_zero, m_axis_tvalid && !res.ok, m_axis_tdata == 96'd0, "failed result not cleared")
  `GDAU_ASSERT_IMP(a_date_sane, m_axis_tvalid && res.ok, (res.month >= 4'd1) && (res.month <= 4'd12) && (res.day >= 5'd1) && (res.day <= res.month_length), "result date out of calendar")
  `GDAU_ASSERT_IMP(a_order_diff, m_axis_tvalid && res.ok && (res.order == 2'sd0), res.day_diff == 23'sd0, "order and difference disagree")

endmodule

/* test/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// checks the gregorian date unit against an in-bench calendar predictor
// ---------------------------------------------------------------------------
// Directed dates at the range limits, every command and the invalid cases,
// then random requests with bursty input and a stalling output. Every
// result is compared field by field with the oldest expected date.
module testbench;

  typedef struct {
    logic [3:0]         cmd;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [22:0] offset;
    logic [13:0]        year_b;
    logic [3:0]         month_b;
    logic [4:0]         day_b;
  } date_req_t;

  localparam longint DN_LO = -719528;
  localparam longint DN_HI = 2932896;
  localparam int     STALL_LIMIT = 5000;

  function automatic bit leap_year(longint y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic longint days_in_month(longint y, longint m);
    longint lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 0;
    if (m == 2 && leap_year(y)) return 29;
    return lens[m];
  endfunction

  function automatic bit date_ok(longint y, longint m, longint d);
    if (y > 9999 || m < 1 || m > 12) return 0;
    return d >= 1 && d <= days_in_month(y, m);
  endfunction

  function automatic longint epoch_days(longint y, longint m, longint d);
    longint a, yy, mm;
    a  = (14 - m) / 12;
    yy = y + 4800 - a;
    mm = m + 12 * a - 3;
    return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045
           - 2440588;
  endfunction

  function automatic void civil_date(longint dn, output longint y, output longint m,
                                     output longint d);
    longint a, b, c, dd, e, mm;
    a  = dn + 2440588 + 32044;
    b  = (4 * a + 3) / 146097;
    c  = a - (146097 * b) / 4;
    dd = (4 * c + 3) / 1461;
    e  = c - (1461 * dd) / 4;
    mm = (5 * e + 2) / 153;
    d  = e - (153 * mm + 2) / 5 + 1;
    m  = mm + 3 - 12 * (mm / 10);
    y  = 100 * b + dd - 4800 + mm / 10;
  endfunction

  function automatic gdau_pkg::res_t compute_date(date_req_t r);
    longint y, m, d, off, ry, rm, rd, dn, tot, diff, ord, wd;
    longint cum[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    bit             valid, ok;
    gdau_pkg::res_t o;
    y = r.year; m = r.month; d = r.day; off = r.offset;
    valid = date_ok(y, m, d);
    ok = 0; ry = 0; rm = 0; rd = 0; diff = 0; ord = 0;
    case (r.cmd)
      gdau_pkg::CMD_QUERY: begin
        ok = valid; ry = y; rm = m; rd = d;
      end
      gdau_pkg::CMD_FROM_DAYS, gdau_pkg::CMD_ADD_DAYS: begin
        dn = off;
        if (r.cmd == gdau_pkg::CMD_ADD_DAYS) dn = valid ? epoch_days(y, m, d) + off : DN_HI + 1;
        if (dn >= DN_LO && dn <= DN_HI) begin
          civil_date(dn, ry, rm, rd);
          ok = 1;
        end
      end
      gdau_pkg::CMD_ADD_MONTHS: if (valid) begin
        tot = y * 12 + (m - 1) + off;
        if (tot >= 0 && tot / 12 <= 9999) begin
          ry = tot / 12; rm = tot % 12 + 1; rd = d;
          if (rd > days_in_month(ry, rm)) rd = days_in_month(ry, rm);
          ok = 1;
        end
      end
      gdau_pkg::CMD_ADD_YEARS: if (valid) begin
        ry = y + off;
        if (ry >= 0 && ry <= 9999) begin
          rm = m; rd = d;
          if (rm == 2 && rd == 29 && !leap_year(ry)) rd = 28;
          ok = 1;
        end
      end
      gdau_pkg::CMD_DIFF: if (valid && date_ok(r.year_b, r.month_b, r.day_b)) begin
        ry = y; rm = m; rd = d;
        diff = epoch_days(y, m, d) - epoch_days(r.year_b, r.month_b, r.day_b);
        ord = diff < 0 ? -1 : (diff > 0 ? 1 : 0);
        ok = 1;
      end
      gdau_pkg::CMD_MONTH_START, gdau_pkg::CMD_MONTH_END, gdau_pkg::CMD_YEAR_START,
      gdau_pkg::CMD_YEAR_END: if (valid) begin
        ry = y;
        rm = (r.cmd == gdau_pkg::CMD_YEAR_START) ? 1
           : (r.cmd == gdau_pkg::CMD_YEAR_END ? 12 : m);
        rd = (r.cmd == gdau_pkg::CMD_MONTH_END) ? days_in_month(y, m)
                                                : (r.cmd == gdau_pkg::CMD_YEAR_END ? 31 : 1);
        ok = 1;
      end
      default: ok = 0;
    endcase
    o = '0;
    if (ok) begin
      dn = epoch_days(ry, rm, rd);
      wd = (dn + 4) % 7;
      if (wd < 0) wd += 7;
      o.ok           = 1'b1;
      o.year         = 14'(ry);
      o.month        = 4'(rm);
      o.day          = 5'(rd);
      o.day_number   = 23'(dn);
      o.weekday      = 3'(wd);
      o.day_of_year  = 9'(cum[rm] + ((rm > 2 && leap_year(ry)) ? 1 : 0) + rd);
      o.leap         = leap_year(ry);
      o.month_length = 5'(days_in_month(ry, rm));
      o.day_diff     = 23'(diff);
      o.order        = 2'(ord);
    end
    return o;
  endfunction

  class date_scoreboard;
    gdau_pkg::res_t expected_dates[$];
    int             errors = 0;

    function void note_request(date_req_t r);
      expected_dates.push_back(compute_date(r));
    endfunction

    function void field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(gdau_pkg::res_t act);
      gdau_pkg::res_t e;
      if (expected_dates.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, act);
        errors++;
        return;
      end
      e = expected_dates.pop_front();
      field("ok", e.ok, act.ok);
      field("year", e.year, act.year);
      field("month", e.month, act.month);
      field("day", e.day, act.day);
      field("day_number", e.day_number, act.day_number);
      field("weekday", e.weekday, act.weekday);
      field("day_of_year", e.day_of_year, act.day_of_year);
      field("leap", e.leap, act.leap);
      field("month_length", e.month_length, act.month_length);
      field("day_diff", e.day_diff, act.day_diff);
      field("order", e.order, act.order);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  date_scoreboard sb = new();
  int hold_cycles = 0;
  int burst_left = 0;
  int idle_count = 0;

  gregorian_date_arithmetic_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    date_req_t      r;
    gdau_pkg::res_t a;
    if (s_axis_tvalid && s_axis_tready) begin
      r.cmd     = s_axis_tuser;
      r.year    = s_axis_tdata[13:0];
      r.month   = s_axis_tdata[17:14];
      r.day     = s_axis_tdata[22:18];
      r.offset  = s_axis_tdata[45:23];
      r.year_b  = s_axis_tdata[59:46];
      r.month_b = s_axis_tdata[63:60];
      r.day_b   = s_axis_tdata[68:64];
      sb.note_request(r);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      a.ok           = m_axis_tuser[0];
      a.year         = m_axis_tdata[13:0];
      a.month        = m_axis_tdata[17:14];
      a.day          = m_axis_tdata[22:18];
      a.day_number   = m_axis_tdata[45:23];
      a.weekday      = m_axis_tdata[48:46];
      a.day_of_year  = m_axis_tdata[57:49];
      a.leap         = m_axis_tdata[58];
      a.month_length = m_axis_tdata[63:59];
      a.day_diff     = m_axis_tdata[86:64];
      a.order        = m_axis_tdata[88:87];
      sb.check_result(a);
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_count <= 0;
    else if (rst_ni) begin
      idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // output stall pattern, with one long hold-off
  initial begin
    int mode;
    int run;
    run = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        if (run == 0) begin
          mode = $urandom_range(0, 3);
          run = $urandom_range(1, 40);
        end
        run--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 1) != 0);
          default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic send(date_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.cmd;
    s_axis_tdata  <= {3'b000, r.day_b, r.month_b, r.year_b, r.offset, r.day, r.month,
                      r.year};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.expected_dates.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic date_req_t mk(logic [3:0] c, int y, int m, int d, int off = 0,
                                   int yb = 2000, int mb = 1, int db = 1);
    date_req_t r;
    r.cmd = c; r.year = 14'(y); r.month = 4'(m); r.day = 5'(d); r.offset = 23'(off);
    r.year_b = 14'(yb); r.month_b = 4'(mb); r.day_b = 5'(db);
    return r;
  endfunction

  function automatic void rand_date(output logic [13:0] y, output logic [3:0] m,
                                    output logic [4:0] d);
    int picks[5] = '{0, 9999, 1600, 1900, 2000};
    if ($urandom_range(0, 9) == 0) begin
      y = 14'($urandom); m = 4'($urandom); d = 5'($urandom);
    end else begin
      y = ($urandom_range(0, 5) == 0) ? 14'(picks[$urandom_range(0, 4)])
                                      : 14'($urandom_range(0, 9999));
      m = 4'($urandom_range(1, 12));
      d = 5'($urandom_range(1, int'(days_in_month(y, m))));
    end
  endfunction

  function automatic date_req_t rand_req();
    date_req_t r;
    rand_date(r.year, r.month, r.day);
    rand_date(r.year_b, r.month_b, r.day_b);
    r.cmd = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
    case ($urandom_range(0, 4))
      0:       r.offset = 23'($urandom);
      1:       r.offset = 23'(int'($urandom_range(0, 40)) - 20);
      default: case (r.cmd)
        gdau_pkg::CMD_FROM_DAYS:  r.offset = 23'(int'($urandom_range(0, 3652800)) - 719600);
        gdau_pkg::CMD_ADD_DAYS:   r.offset = 23'(int'($urandom_range(0, 800000)) - 400000);
        gdau_pkg::CMD_ADD_MONTHS: r.offset = 23'(int'($urandom_range(0, 240000)) - 120000);
        gdau_pkg::CMD_ADD_YEARS:  r.offset = 23'(int'($urandom_range(0, 20000)) - 10000);
        default:                  r.offset = 23'($urandom);
      endcase
    endcase
    return r;
  endfunction

  initial begin
    date_req_t directed[$];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      mk(gdau_pkg::CMD_QUERY, 0, 1, 1), mk(gdau_pkg::CMD_QUERY, 9999, 12, 31),
      mk(gdau_pkg::CMD_QUERY, 16383, 15, 31), mk(gdau_pkg::CMD_QUERY, 2000, 0, 1),
      mk(gdau_pkg::CMD_QUERY, 1900, 2, 29), mk(gdau_pkg::CMD_QUERY, 2000, 2, 29),
      mk(gdau_pkg::CMD_QUERY, 10000, 1, 1), mk(gdau_pkg::CMD_QUERY, 2021, 4, 0),
      mk(gdau_pkg::CMD_FROM_DAYS, 0, 0, 0, -719528),
      mk(gdau_pkg::CMD_FROM_DAYS, 0, 0, 0, 2932896),
      mk(gdau_pkg::CMD_FROM_DAYS, 0, 0, 0, -719529),
      mk(gdau_pkg::CMD_FROM_DAYS, 0, 0, 0, 2932897),
      mk(gdau_pkg::CMD_FROM_DAYS, 0, 0, 0, -1),
      mk(gdau_pkg::CMD_ADD_DAYS, 1999, 12, 31, 4194303),
      mk(gdau_pkg::CMD_ADD_DAYS, 0, 1, 1, -4194304),
      mk(gdau_pkg::CMD_ADD_MONTHS, 2023, 1, 31, 1),
      mk(gdau_pkg::CMD_ADD_MONTHS, 0, 1, 1, -1),
      mk(gdau_pkg::CMD_ADD_YEARS, 2000, 2, 29, 1),
      mk(gdau_pkg::CMD_ADD_YEARS, 9999, 1, 1, 1),
      mk(gdau_pkg::CMD_DIFF, 0, 1, 1, 0, 9999, 12, 31),
      mk(gdau_pkg::CMD_DIFF, 2020, 5, 5, 0, 2020, 5, 5),
      mk(gdau_pkg::CMD_DIFF, 2020, 5, 5, 0, 2020, 13, 5),
      mk(gdau_pkg::CMD_MONTH_END, 2024, 2, 10), mk(gdau_pkg::CMD_YEAR_END, 1, 6, 6),
      mk(gdau_pkg::CMD_MONTH_START, 5, 5, 5), mk(gdau_pkg::CMD_YEAR_START, 7, 7, 7),
      mk(4'd15, 2000, 1, 1)
    };
    foreach (directed[i]) send(directed[i]);
    drain();

    for (int i = 0; i < 1500; i++) begin
      if (i == 500) hold_cycles = 300;
      if (i == 1000) drain();
      send(rand_req());
    end
    drain();

    if (sb.errors == 0 && sb.expected_dates.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
